// File: hw/rtl/mdb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdb_pkg
// Shared types, codes and response tables of the cashless reader.
// ----------------------------------------------------------------------------
package mdb_pkg;

  localparam int unsigned MaxBytes = 34;
  localparam int unsigned IdxW     = $clog2(MaxBytes);

  // command kinds
  localparam logic [2:0] OP_RESET     = 3'd0;
  localparam logic [2:0] OP_POLL      = 3'd1;
  localparam logic [2:0] OP_SETUP     = 3'd2;
  localparam logic [2:0] OP_VEND      = 3'd3;
  localparam logic [2:0] OP_READER    = 3'd4;
  localparam logic [2:0] OP_EXPANSION = 3'd5;

  // register indexes
  localparam logic [1:0] REG_CREDIT_MODE    = 2'd0;
  localparam logic [1:0] REG_SESSION_CREDIT = 2'd1;
  localparam logic [1:0] REG_MAX_AMOUNT     = 2'd2;
  localparam logic [1:0] REG_IDLE_LIMIT     = 2'd3;

  // delayed messages
  localparam logic [2:0] PEND_NONE       = 3'd0;
  localparam logic [2:0] PEND_JUST_RESET = 3'd1;
  localparam logic [2:0] PEND_CONFIG     = 3'd2;
  localparam logic [2:0] PEND_READER_ID  = 3'd3;
  localparam logic [2:0] PEND_OUT_SEQ    = 3'd4;
  localparam logic [2:0] PEND_EXP_ID     = 3'd5;
  localparam logic [2:0] PEND_DISPLAY    = 3'd6;

  // response kinds; the delayed messages keep their own codes
  localparam logic [3:0] MSG_ZERO       = 4'd0;
  localparam logic [3:0] MSG_JUST_RESET = 4'd1;
  localparam logic [3:0] MSG_CONFIG     = 4'd2;
  localparam logic [3:0] MSG_READER_ID  = 4'd3;
  localparam logic [3:0] MSG_OUT_SEQ    = 4'd4;
  localparam logic [3:0] MSG_EXP_ID     = 4'd5;
  localparam logic [3:0] MSG_DISPLAY    = 4'd6;
  localparam logic [3:0] MSG_CANCEL     = 4'd7;
  localparam logic [3:0] MSG_END        = 4'd8;
  localparam logic [3:0] MSG_BEGIN      = 4'd9;
  localparam logic [3:0] MSG_APPROVED   = 4'd10;

  localparam logic [7:0] CODE_BEGIN    = 8'h03;
  localparam logic [7:0] CODE_APPROVED = 8'h05;

  // vend outcome
  localparam logic [1:0] OUT_NOTHING = 2'd0;
  localparam logic [1:0] OUT_CANCEL  = 2'd1;
  localparam logic [1:0] OUT_SUCCESS = 2'd2;
  localparam logic [1:0] OUT_FAILURE = 2'd3;

  // host notices
  localparam logic [1:0] NOTE_NONE      = 2'd0;
  localparam logic [1:0] NOTE_ENABLED   = 2'd1;
  localparam logic [1:0] NOTE_CANCELLED = 2'd2;
  localparam logic [1:0] NOTE_VEND      = 2'd3;

  typedef enum logic [4:0] {
    ST_OFFLINE = 5'b00001,
    ST_STANDBY = 5'b00010,
    ST_READY   = 5'b00100,
    ST_IDLE    = 5'b01000,
    ST_VEND    = 5'b10000
  } state_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] amount;
    logic        led;
    logic [1:0]  notify;
    logic [15:0] nprice;
  } resp_desc_t;

  typedef struct packed {
    logic full;
    logic valid;
  } fifo_status_t;

  localparam logic [7:0] TAB_CONFIG [9] = '{
    8'h01, 8'h01, 8'h2A, 8'h11, 8'h01, 8'h00, 8'h0A, 8'h00, 8'h48};

  localparam logic [7:0] TAB_READER_ID [31] = '{
    8'h09, 8'h43, 8'h4F, 8'h4D, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30,
    8'h31, 8'h34, 8'h35, 8'h33, 8'h38, 8'h36, 8'h4E, 8'h45, 8'h57, 8'h5F,
    8'h45, 8'h55, 8'h52, 8'h4F, 8'h4B, 8'h45, 8'h59, 8'h20, 8'h02, 8'h01,
    8'hD3};

  localparam logic [7:0] TAB_EXP_ID [4] = '{8'h01, 8'h02, 8'hFF, 8'h02};

  localparam logic [7:0] TAB_DISPLAY [34] = '{
    8'h02, 8'h64, 8'h54, 8'h4F, 8'h55, 8'h43, 8'h48, 8'h20, 8'h43, 8'h41,
    8'h52, 8'h44, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
    8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
    8'h20, 8'h20, 8'h20, 8'hC1};

  function automatic logic [IdxW-1:0] msg_len(input logic [3:0] kind);
    logic [IdxW-1:0] len;
    case (kind)
      MSG_ZERO:       len = IdxW'(1);
      MSG_JUST_RESET: len = IdxW'(2);
      MSG_CONFIG:     len = IdxW'(9);
      MSG_READER_ID:  len = IdxW'(31);
      MSG_OUT_SEQ:    len = IdxW'(2);
      MSG_EXP_ID:     len = IdxW'(4);
      MSG_DISPLAY:    len = IdxW'(34);
      MSG_CANCEL:     len = IdxW'(2);
      MSG_END:        len = IdxW'(2);
      MSG_BEGIN:      len = IdxW'(4);
      MSG_APPROVED:   len = IdxW'(4);
      default:        len = IdxW'(1);
    endcase
    return len;
  endfunction

  function automatic logic [7:0] amount_byte(input logic [7:0] code,
                                             input logic [15:0] amt,
                                             input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = code;
      2'd1:    b = amt[15:8];
      2'd2:    b = amt[7:0];
      default: b = code + amt[15:8] + amt[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] msg_byte(input logic [3:0] kind,
                                          input logic [IdxW-1:0] idx,
                                          input logic [15:0] amt);
    logic [7:0] b;
    case (kind)
      MSG_ZERO:       b = 8'h00;
      MSG_JUST_RESET: b = 8'h00;
      MSG_CONFIG:     b = TAB_CONFIG[idx[3:0]];
      MSG_READER_ID:  b = TAB_READER_ID[idx[4:0]];
      MSG_OUT_SEQ:    b = 8'h0B;
      MSG_EXP_ID:     b = TAB_EXP_ID[idx[1:0]];
      MSG_DISPLAY:    b = TAB_DISPLAY[idx];
      MSG_CANCEL:     b = 8'h04;
      MSG_END:        b = 8'h07;
      MSG_BEGIN:      b = amount_byte(CODE_BEGIN, amt, idx[1:0]);
      MSG_APPROVED:   b = amount_byte(CODE_APPROVED, amt, idx[1:0]);
      default:        b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mdb_cashless_reader_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdb_cashless_reader_fsm
// Slave side of a vending-bus cashless reader.
//
// Slave stream: one decoded master command per transfer, kind in s_tuser.
// Master stream: one response byte per transfer, m_tlast on the final byte.
// Commands that need no answer produce no transfer at all.
// The decoder updates the reader state in the cycle of the transfer and
// queues a response descriptor; the byte sender expands it from tables.
// Path: with the sender free, a command's descriptor is written into the queue
// register, then loaded into the sender, which then presents the first byte.
// Throughput: one byte per cycle while m_tready is high; a response holds up to
// 34 bytes, and a silent command does not use the sender. Commands keep
// flowing until two descriptors wait in the queue.
// Reset clears state and restores register defaults; no pass is needed.
// A stalled master holds the current byte; the queue then fills and
// s_tready drops until bytes drain.
// Registers: 0 credit_mode, 1 session_credit, 2 max_amount,
// 3 idle_poll_limit, written through cfg_we / cfg_index / cfg_data.
// ----------------------------------------------------------------------------
module mdb_cashless_reader_fsm
  import mdb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // sub[7:0], price_high[15:8], price_low[23:16], host_balance[39:24]
  input  wire logic [39:0] s_tdata,
  // op[2:0]
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // resp_byte[7:0], session_led[8], notify[10:9], notify_price[26:11]
  output logic [31:0]      m_tdata,
  output logic             m_tlast
);

  logic         accept;
  logic         push;
  logic         pop;
  resp_desc_t   desc;
  resp_desc_t   q_data;
  fifo_status_t q_status;

  assign s_tready = ~q_status.full;
  assign accept   = s_tvalid & s_tready;

  mdb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd_valid    (accept),
    .op           (s_tuser),
    .sub          (s_tdata[7:0]),
    .price_high   (s_tdata[15:8]),
    .price_low    (s_tdata[23:16]),
    .host_balance (s_tdata[39:24]),
    .push         (push),
    .desc         (desc)
  );

  mdb_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (desc),
    .pop    (pop),
    .rdata  (q_data),
    .status (q_status)
  );

  mdb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_data   (q_data),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

// File: hw/rtl/mdb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdb_front
// Command decoder: holds the reader state and issues one response
// descriptor per command that answers.
// ----------------------------------------------------------------------------
module mdb_front
  import mdb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        cmd_valid,
  input  wire logic [2:0]  op,
  input  wire logic [7:0]  sub,
  input  wire logic [7:0]  price_high,
  input  wire logic [7:0]  price_low,
  input  wire logic [15:0] host_balance,
  output logic             push,
  output resp_desc_t       desc
);

  logic        credit_mode;
  logic [15:0] session_credit;
  logic [15:0] max_amount;
  logic [7:0]  idle_poll_limit;

  state_t      state, state_next;
  logic [2:0]  pending, pending_next;
  logic        follow, follow_next;
  logic [1:0]  outcome, outcome_next;
  logic [7:0]  idle_polls, idle_polls_next;
  logic [15:0] balance, balance_next;
  logic [15:0] price, price_next;
  logic        led, led_next;
  logic        answer;
  logic [8:0]  polls_inc;
  logic [15:0] offer;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit_mode     <= 1'b0;
      session_credit  <= 16'd3000;
      max_amount      <= 16'd65000;
      idle_poll_limit <= 8'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CREDIT_MODE:    credit_mode     <= cfg_data[0];
        REG_SESSION_CREDIT: session_credit  <= cfg_data;
        REG_MAX_AMOUNT:     max_amount      <= cfg_data;
        REG_IDLE_LIMIT:     idle_poll_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign polls_inc = {1'b0, idle_polls} + 9'd1;

  always_comb begin
    if (credit_mode) begin
      offer = (host_balance > max_amount) ? max_amount : host_balance;
    end else begin
      offer = session_credit;
    end
  end

  always_comb begin
    state_next      = state;
    pending_next    = pending;
    follow_next     = follow;
    outcome_next    = outcome;
    idle_polls_next = idle_polls;
    balance_next    = balance;
    price_next      = price;
    led_next        = led;
    answer          = 1'b0;
    desc            = '0;
    desc.kind       = MSG_ZERO;
    case (state)
      ST_OFFLINE: begin
        led_next = 1'b0;
        case (op)
          OP_RESET: begin
            answer       = 1'b1;
            pending_next = PEND_JUST_RESET;
          end
          OP_POLL: begin
            answer = 1'b1;
            if (pending != PEND_NONE) begin
              desc.kind    = {1'b0, pending};
              pending_next = PEND_NONE;
              if (follow) begin
                state_next  = ST_STANDBY;
                follow_next = 1'b0;
              end
            end
          end
          OP_SETUP: begin
            if (sub == 8'd0) begin
              answer       = 1'b1;
              pending_next = PEND_CONFIG;
            end else if (sub == 8'd1) begin
              answer = 1'b1;
            end
          end
          OP_EXPANSION: begin
            if (sub == 8'd0) begin
              answer       = 1'b1;
              pending_next = PEND_READER_ID;
              follow_next  = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_STANDBY: begin
        case (op)
          OP_RESET: begin
            answer       = 1'b1;
            pending_next = PEND_JUST_RESET;
            state_next   = ST_OFFLINE;
          end
          OP_POLL: begin
            answer = 1'b1;
            if (pending != PEND_NONE) begin
              desc.kind    = {1'b0, pending};
              pending_next = PEND_NONE;
            end
          end
          OP_READER: begin
            if (sub == 8'd1) begin
              answer      = 1'b1;
              state_next  = ST_READY;
              desc.notify = NOTE_ENABLED;
            end else if (sub == 8'd0) begin
              answer = 1'b1;
            end else if (sub == 8'd2) begin
              pending_next = PEND_OUT_SEQ;
            end
          end
          OP_EXPANSION: begin
            if (sub == 8'd0) begin
              answer       = 1'b1;
              pending_next = PEND_EXP_ID;
            end
          end
          default: ;
        endcase
      end
      ST_READY: begin
        case (op)
          OP_RESET: begin
            answer       = 1'b1;
            pending_next = PEND_JUST_RESET;
            state_next   = ST_OFFLINE;
          end
          OP_POLL: begin
            answer = 1'b1;
            if (host_balance != 16'd0) begin
              led_next     = 1'b1;
              balance_next = offer;
              desc.kind    = MSG_BEGIN;
              desc.amount  = offer;
              outcome_next = OUT_NOTHING;
              state_next   = ST_IDLE;
            end else begin
              balance_next = host_balance;
            end
          end
          OP_READER: begin
            if (sub == 8'd0) begin
              answer       = 1'b1;
              pending_next = PEND_DISPLAY;
            end else if (sub == 8'd1) begin
              answer = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_IDLE: begin
        case (op)
          OP_RESET: begin
            answer       = 1'b1;
            pending_next = PEND_JUST_RESET;
            state_next   = ST_OFFLINE;
          end
          OP_VEND: begin
            if (sub == 8'd0) begin
              answer     = 1'b1;
              price_next = {price_high, price_low};
              state_next = ST_VEND;
            end else if (sub == 8'd1 || sub == 8'd4) begin
              answer = 1'b1;
            end
          end
          OP_POLL: begin
            if (outcome == OUT_NOTHING) begin
              answer = 1'b1;
              if (polls_inc > {1'b0, idle_poll_limit}) begin
                outcome_next    = OUT_CANCEL;
                idle_polls_next = 8'd0;
              end else begin
                idle_polls_next = polls_inc[7:0];
              end
            end else if (outcome == OUT_CANCEL || outcome == OUT_SUCCESS) begin
              answer = 1'b1;
              if (outcome == OUT_CANCEL) begin
                desc.kind   = MSG_CANCEL;
                desc.notify = NOTE_CANCELLED;
              end else begin
                desc.kind   = MSG_END;
                desc.notify = NOTE_VEND;
                desc.nprice = price;
              end
              state_next      = ST_READY;
              led_next        = 1'b0;
              idle_polls_next = 8'd0;
              balance_next    = 16'd0;
              price_next      = 16'd0;
            end
          end
          default: ;
        endcase
      end
      ST_VEND: begin
        case (op)
          OP_RESET: begin
            answer       = 1'b1;
            pending_next = PEND_JUST_RESET;
            state_next   = ST_OFFLINE;
          end
          OP_POLL: begin
            answer       = 1'b1;
            balance_next = balance - price;
            desc.kind    = MSG_APPROVED;
            desc.amount  = balance - price;
          end
          OP_VEND: begin
            if (sub == 8'd1) begin
              answer       = 1'b1;
              outcome_next = OUT_CANCEL;
            end else if (sub == 8'd2 || sub == 8'd4) begin
              answer       = 1'b1;
              state_next   = ST_IDLE;
              outcome_next = OUT_SUCCESS;
            end else if (sub == 8'd3) begin
              answer       = 1'b1;
              outcome_next = OUT_FAILURE;
              balance_next = balance + price;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    desc.led = led_next;
  end

  assign push = cmd_valid & answer;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_OFFLINE;
      pending    <= PEND_NONE;
      follow     <= 1'b0;
      outcome    <= OUT_NOTHING;
      idle_polls <= 8'd0;
      balance    <= 16'd3000;
      price      <= 16'd0;
      led        <= 1'b0;
    end else if (cmd_valid) begin
      state      <= state_next;
      pending    <= pending_next;
      follow     <= follow_next;
      outcome    <= outcome_next;
      idle_polls <= idle_polls_next;
      balance    <= balance_next;
      price      <= price_next;
      led        <= led_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/mdb_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdb_fifo
// Two-entry descriptor queue between decoder and byte sender.
// ----------------------------------------------------------------------------
module mdb_fifo
  import mdb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire resp_desc_t  wdata,
  input  wire logic        pop,
  output resp_desc_t       rdata,
  output fifo_status_t     status
);

  resp_desc_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign status.full  = (count == 2'd2);
  assign status.valid = (count != 2'd0);
  assign rdata        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/mdb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdb_back
// Byte sender: expands one descriptor into its response bytes, one per
// transfer.
// ----------------------------------------------------------------------------
module mdb_back
  import mdb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire fifo_status_t q_status,
  input  wire resp_desc_t  q_data,
  output logic             q_pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,
  output logic             m_tlast
);

  resp_desc_t      cur;
  logic            busy;
  logic [IdxW-1:0] idx;
  logic            last;

  assign last     = (idx == msg_len(cur.kind) - IdxW'(1));
  assign m_tvalid = busy;
  assign m_tlast  = last;
  assign m_tdata  = {5'd0, cur.nprice, cur.notify, cur.led,
                     msg_byte(cur.kind, idx, cur.amount)};
  assign q_pop    = q_status.valid & (~busy | (m_tready & last));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && m_tready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + IdxW'(1);
      end
    end
  end

endmodule
`default_nettype wire
